>>> src/lfpid_pkg.sv
`default_nettype none

package lfpid_pkg;

    // Field widths fixed by the register map and the result format
    localparam int THR_W      = 12;
    localparam int GAIN_W     = 18;
    localparam int DRIVE_W    = 16;
    localparam int MODE_W     = 2;
    localparam int INTEG_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Register reset values
    localparam logic [THR_W-1:0]   RST_DARK_THRESHOLD   = THR_W'(2000);
    localparam logic [GAIN_W-1:0]  RST_GAIN_PROP        = GAIN_W'(188744);
    localparam logic [GAIN_W-1:0]  RST_GAIN_INTEGRAL    = GAIN_W'(210);
    localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV       = GAIN_W'(5243);
    localparam logic [DRIVE_W-1:0] RST_LEFT_BASE_DRIVE  = DRIVE_W'(3825);
    localparam logic [DRIVE_W-1:0] RST_RIGHT_BASE_DRIVE = DRIVE_W'(5400);
    localparam logic [DRIVE_W-1:0] RST_LEFT_TRIM_LIMIT  = DRIVE_W'(890);
    localparam logic [DRIVE_W-1:0] RST_RIGHT_TRIM_LIMIT = DRIVE_W'(600);

    // Drive value presented before the first steering decision
    localparam logic [DRIVE_W-1:0] RST_HELD_DRIVE = DRIVE_W'(4500);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DARK_THRESHOLD   = 3'd0,
        REG_GAIN_PROP        = 3'd1,
        REG_GAIN_INTEGRAL    = 3'd2,
        REG_GAIN_DERIV       = 3'd3,
        REG_LEFT_BASE_DRIVE  = 3'd4,
        REG_RIGHT_BASE_DRIVE = 3'd5,
        REG_LEFT_TRIM_LIMIT  = 3'd6,
        REG_RIGHT_TRIM_LIMIT = 3'd7
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 2'd0,
        MODE_STRAIGHT = 2'd1,
        MODE_LEFT     = 2'd2,
        MODE_RIGHT    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [THR_W-1:0]   dark_threshold;
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_integral;
        logic [GAIN_W-1:0]  gain_deriv;
        logic [DRIVE_W-1:0] left_base_drive;
        logic [DRIVE_W-1:0] right_base_drive;
        logic [DRIVE_W-1:0] left_trim_limit;
        logic [DRIVE_W-1:0] right_trim_limit;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/lfpid_cfg.sv
`default_nettype none

module lfpid_cfg
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [lfpid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lfpid_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lfpid_pkg::cfg_t                         cfg
);
    import lfpid_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DARK_THRESHOLD:   cfg_next.dark_threshold   = cfg_data[THR_W-1:0];
                REG_GAIN_PROP:        cfg_next.gain_prop        = cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEGRAL:    cfg_next.gain_integral    = cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV:       cfg_next.gain_deriv       = cfg_data[GAIN_W-1:0];
                REG_LEFT_BASE_DRIVE:  cfg_next.left_base_drive  = cfg_data[DRIVE_W-1:0];
                REG_RIGHT_BASE_DRIVE: cfg_next.right_base_drive = cfg_data[DRIVE_W-1:0];
                REG_LEFT_TRIM_LIMIT:  cfg_next.left_trim_limit  = cfg_data[DRIVE_W-1:0];
                REG_RIGHT_TRIM_LIMIT: cfg_next.right_trim_limit = cfg_data[DRIVE_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold   <= RST_DARK_THRESHOLD;
            cfg_reg.gain_prop        <= RST_GAIN_PROP;
            cfg_reg.gain_integral    <= RST_GAIN_INTEGRAL;
            cfg_reg.gain_deriv       <= RST_GAIN_DERIV;
            cfg_reg.left_base_drive  <= RST_LEFT_BASE_DRIVE;
            cfg_reg.right_base_drive <= RST_RIGHT_BASE_DRIVE;
            cfg_reg.left_trim_limit  <= RST_LEFT_TRIM_LIMIT;
            cfg_reg.right_trim_limit <= RST_RIGHT_TRIM_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/lfpid_pid.sv
`default_nettype none

module lfpid_pid
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 20
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               update,
    input  wire logic signed [SAMPLE_BITS:0]        err,
    input  wire logic [lfpid_pkg::GAIN_W-1:0]       gain_prop,
    input  wire logic [lfpid_pkg::GAIN_W-1:0]       gain_integral,
    input  wire logic [lfpid_pkg::GAIN_W-1:0]       gain_deriv,
    input  wire logic [lfpid_pkg::DRIVE_W-1:0]      limit,
    output logic [lfpid_pkg::DRIVE_W-1:0]           corr
);
    import lfpid_pkg::*;

    localparam int E_W    = SAMPLE_BITS + 1;
    localparam int PP_W   = GAIN_W + 1 + E_W;
    localparam int PD_W   = GAIN_W + 1 + E_W + 1;
    localparam int PI_W   = GAIN_W + 1 + INTEG_W;
    localparam int ACC_W  = PI_W + 2;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [INTEG_W-1:0] integral_next;
    logic signed [E_W-1:0]     prev_err_reg;

    logic signed [INTEG_W:0]   sum_wide;
    logic signed [E_W:0]       diff;
    logic signed [GAIN_W:0]    gp_s;
    logic signed [GAIN_W:0]    gi_s;
    logic signed [GAIN_W:0]    gd_s;
    logic signed [PP_W-1:0]    p_prop;
    logic signed [PD_W-1:0]    p_der;
    logic signed [PI_W-1:0]    p_int;
    logic signed [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]          mag;

    // Saturating integral update
    always_comb
    begin
        sum_wide = (INTEG_W+1)'(integral_reg) + (INTEG_W+1)'(err);
        if (sum_wide[INTEG_W] != sum_wide[INTEG_W-1])
            integral_next = sum_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
            integral_next = sum_wide[INTEG_W-1:0];
    end

    // Three gain products side by side, then one sum and clamp
    always_comb
    begin
        diff   = (E_W+1)'(err) - (E_W+1)'(prev_err_reg);
        gp_s   = {1'b0, gain_prop};
        gi_s   = {1'b0, gain_integral};
        gd_s   = {1'b0, gain_deriv};
        p_prop = gp_s * err;
        p_der  = gd_s * diff;
        p_int  = gi_s * integral_next;
        acc    = ACC_W'(p_prop) + ACC_W'(p_der) + ACC_W'(p_int);
        mag    = ACC_W'(unsigned'(acc)) >> GAIN_FRAC_BITS;
        if (acc[ACC_W-1] || (acc == '0))
            corr = '0;
        else if (mag > ACC_W'(limit))
            corr = limit;
        else
            corr = mag[DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (update)
        begin
            integral_reg <= integral_next;
            prev_err_reg <= err;
        end
    end

    a_corr_within_limit : assert property (@(posedge clk) disable iff (!rst_n)
        update |-> corr <= limit)
        else $error("pid correction above trim limit");

    a_state_holds_without_update : assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> $stable(integral_reg) && $stable(prev_err_reg))
        else $error("pid state changed without an update");

endmodule

`default_nettype wire

>>> src/line_follow_pid_motor_drive_top.sv
`default_nettype none

// Three-sensor line follower with PID steering. Each input beat carries a left,
// middle and right sensor sample; each accepted beat yields exactly one output
// beat with the two wheel PWM compare values and a steering mode. A middle
// sample above dark_threshold drives straight on the base values; otherwise the
// left, then the right sample selects a turn, where error = side - middle feeds
// a PID (saturating 32-bit integral, derivative against the last turn error,
// unsigned Q0.20 gains) whose floored, non-negative correction is clamped to the
// side's trim limit and added to the left base or taken from the right base.
// With no sensor on the line the previous drives and mode repeat. Rate: one beat
// per clock sustained while out_stall is low; each beat passes the input
// register, then the result register that also holds the PID state and the last
// drives. The critical path is the three parallel gain multiplies followed by the
// sum and clamp. Configuration is written through a plain write port and must
// only change while no beat is in flight. Reset output state is 4500 on both
// drives, mode 0.

module line_follow_pid_motor_drive_top
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 20
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_write,
    input  wire logic [lfpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lfpid_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [SAMPLE_BITS-1:0]               left_sample,
    input  wire logic [SAMPLE_BITS-1:0]               middle_sample,
    input  wire logic [SAMPLE_BITS-1:0]               right_sample,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [lfpid_pkg::DRIVE_W-1:0]             left_drive,
    output logic [lfpid_pkg::DRIVE_W-1:0]             right_drive,
    output logic [lfpid_pkg::MODE_W-1:0]              steer_mode
);
    import lfpid_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    cfg_t cfg;

    // input register stage
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [SAMPLE_BITS-1:0]   ls_reg;
    logic [SAMPLE_BITS-1:0]   ms_reg;
    logic [SAMPLE_BITS-1:0]   rs_reg;

    // result register stage; also the held drives and mode
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [DRIVE_W-1:0]       left_drive_reg;
    logic [DRIVE_W-1:0]       left_drive_next;
    logic [DRIVE_W-1:0]       right_drive_reg;
    logic [DRIVE_W-1:0]       right_drive_next;
    mode_t                    mode_reg;
    mode_t                    mode_next;

    logic                     out_free;
    logic                     advance;
    logic                     accept;

    logic                     mid_hit;
    logic                     left_hit;
    logic                     right_hit;
    logic                     pid_update;
    logic signed [SAMPLE_BITS:0] err;
    logic [DRIVE_W-1:0]       limit;
    logic [DRIVE_W-1:0]       corr;
    logic [DRIVE_W:0]         left_sum;

    lfpid_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: stage 1 moves on whenever the result register is empty or
    // being drained this cycle, so a beat can enter every clock.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // Branch selection, priority middle > left > right
    always_comb
    begin
        mid_hit   = CMP_W'(ms_reg) > CMP_W'(cfg.dark_threshold);
        left_hit  = CMP_W'(ls_reg) > CMP_W'(cfg.dark_threshold);
        right_hit = CMP_W'(rs_reg) > CMP_W'(cfg.dark_threshold);

        if (left_hit)
        begin
            err   = $signed({1'b0, ls_reg}) - $signed({1'b0, ms_reg});
            limit = cfg.left_trim_limit;
        end
        else
        begin
            err   = $signed({1'b0, rs_reg}) - $signed({1'b0, ms_reg});
            limit = cfg.right_trim_limit;
        end

        pid_update = advance && !mid_hit && (left_hit || right_hit);
    end

    lfpid_pid
    #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    )
    u_pid
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .update        (pid_update),
        .err           (err),
        .gain_prop     (cfg.gain_prop),
        .gain_integral (cfg.gain_integral),
        .gain_deriv    (cfg.gain_deriv),
        .limit         (limit),
        .corr          (corr)
    );

    // Drive calculation
    always_comb
    begin
        left_sum         = (DRIVE_W+1)'(cfg.left_base_drive) + (DRIVE_W+1)'(corr);
        left_drive_next  = left_drive_reg;
        right_drive_next = right_drive_reg;
        mode_next        = mode_reg;
        if (mid_hit)
        begin
            left_drive_next  = cfg.left_base_drive;
            right_drive_next = cfg.right_base_drive;
            mode_next        = MODE_STRAIGHT;
        end
        else if (left_hit)
        begin
            left_drive_next  = left_sum[DRIVE_W] ? {DRIVE_W{1'b1}} : left_sum[DRIVE_W-1:0];
            right_drive_next = cfg.right_base_drive;
            mode_next        = MODE_LEFT;
        end
        else if (right_hit)
        begin
            left_drive_next  = cfg.left_base_drive;
            right_drive_next = (corr > cfg.right_base_drive) ? '0
                                                             : cfg.right_base_drive - corr;
            mode_next        = MODE_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            left_drive_reg  <= RST_HELD_DRIVE;
            right_drive_reg <= RST_HELD_DRIVE;
            mode_reg        <= MODE_NONE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                left_drive_reg  <= left_drive_next;
                right_drive_reg <= right_drive_next;
                mode_reg        <= mode_next;
            end
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ls_reg <= left_sample;
            ms_reg <= middle_sample;
            rs_reg <= right_sample;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign steer_mode  = mode_reg;

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with stage 1 able to move");

    a_advance_gives_beat : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat not presented");

    a_mode_never_returns_none : assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_NONE |=> mode_reg != MODE_NONE)
        else $error("steering mode fell back to none");

    a_pid_only_on_turn : assert property (@(posedge clk) disable iff (!rst_n)
        pid_update |=> (mode_reg == MODE_LEFT) || (mode_reg == MODE_RIGHT))
        else $error("pid state stepped without a turn result");

endmodule

`default_nettype wire
